[design/dclw_pkg.sv]
// Shared types, codes and constants for the draw command list walker.
// No dependencies; imported by draw_command_list_walker.
package dclw_pkg;

  localparam int MAX_COMMANDS_DEF = 2000;
  localparam int ADDRESS_BITS_DEF = 19;

  localparam int CMD_W    = 16;
  localparam int LINK_W   = 16;
  localparam int FETCH_W  = 19;
  localparam int KIND_W   = 4;
  localparam int PTR_W    = 16;
  localparam int COUNT_W  = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [5:0] ENTRY_STEP = 6'h20;

  // command word bit positions
  localparam int CMD_END_BIT  = 15;
  localparam int CMD_SKIP_BIT = 14;
  localparam int CMD_JUMP_HI  = 13;
  localparam int CMD_JUMP_LO  = 12;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_END   = 2'd2,
    ST_ABORT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_ASSIGN = 2'd1,
    JMP_CALL   = 2'd2,
    JMP_RETURN = 2'd3
  } jump_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_ENTRY = 1'b1
  } in_op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PLOT_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_ENABLE = 1'd1;

  function automatic logic opcode_ok(input logic [KIND_W-1:0] op);
    return op inside {4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10};
  endfunction

endpackage

[design/draw_command_list_walker.sv]
// Command table walker of a sprite chip: decodes each fetched entry and
// produces the next fetch address, draw dispatch and end/abort status.
// Depends on dclw_pkg.
//
// Each input transfer yields exactly one result transfer, produced in the
// cycle after acceptance. The walk state (table pointer, return slot,
// command count, end flags) updates at the accepting edge, so a new item
// is taken every cycle; the single output register is the only stage, and
// the input stalls only while that register holds a result not yet taken.
// A start-of-frame item (tuser 0) rewinds the walk when plot_mode is not
// zero; entry items (tuser 1) are ignored unless a walk is running.
module draw_command_list_walker #(
  parameter int MAX_COMMANDS = dclw_pkg::MAX_COMMANDS_DEF,
  parameter int ADDRESS_BITS = dclw_pkg::ADDRESS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] command_word, [31:16] link_word
  input  logic [31:0]                         in_tdata,
  // [0] operation
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [18:0] fetch_address, [22:19] draw_kind, [23] draw_valid,
  // [25:24] end_status, [41:26] op_pointer, [47:42] zero
  output logic [47:0]                         out_tdata,
  // [1:0] status
  output logic [1:0]                          out_tuser,
  input  logic                                cfg_we,
  input  logic [dclw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dclw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dclw_pkg::*;

  localparam int AW = ADDRESS_BITS;

  // configuration
  logic [1:0] plot_mode_r;
  logic       draw_enable_r;

  // walk state
  logic [AW-1:0]      table_r, table_nxt;
  logic [AW-1:0]      ret_addr_r, ret_addr_nxt;
  logic               ret_valid_r, ret_valid_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [1:0]         end_flags_r, end_flags_nxt;
  logic               running_r, running_nxt;
  logic [PTR_W-1:0]   abort_ptr_r, abort_ptr_nxt;

  // result register
  logic               out_valid_r;
  status_t            status_r, status_nxt;
  logic [FETCH_W-1:0] fetch_r, fetch_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic               dvalid_r, dvalid_nxt;

  logic               accept;
  in_op_t             op;
  logic [CMD_W-1:0]   cmd;
  logic [LINK_W-1:0]  link;
  logic               skip;
  logic [KIND_W-1:0]  opcode;
  jump_t              jump;
  logic [AW-1:0]      seq_addr, target_addr;
  logic [LINK_W+2:0]  link_addr;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign op     = in_op_t'(in_tuser[0]);
  assign cmd    = in_tdata[CMD_W-1:0];
  assign link   = in_tdata[CMD_W +: LINK_W];
  assign skip   = cmd[CMD_SKIP_BIT];
  assign opcode = cmd[KIND_W-1:0];
  assign jump   = jump_t'(cmd[CMD_JUMP_HI:CMD_JUMP_LO]);

  assign seq_addr    = table_r + AW'(ENTRY_STEP);
  assign link_addr   = {link, 3'b000};
  assign target_addr = AW'(link_addr);

  always_comb begin
    table_nxt     = table_r;
    ret_addr_nxt  = ret_addr_r;
    ret_valid_nxt = ret_valid_r;
    count_nxt     = count_r;
    end_flags_nxt = end_flags_r;
    running_nxt   = running_r;
    abort_ptr_nxt = abort_ptr_r;
    status_nxt    = ST_IDLE;
    kind_nxt      = '0;
    dvalid_nxt    = 1'b0;

    if (op == OP_START) begin
      if (plot_mode_r != 2'd0) begin
        table_nxt     = '0;
        ret_addr_nxt  = '0;
        ret_valid_nxt = 1'b0;
        count_nxt     = '0;
        end_flags_nxt = {1'b0, end_flags_r[1]};
        running_nxt   = 1'b1;
        status_nxt    = ST_FETCH;
      end
    end else if (running_r) begin
      if (cmd[CMD_END_BIT] || (32'(count_r) >= MAX_COMMANDS)) begin
        end_flags_nxt = end_flags_r | 2'b10;
        running_nxt   = 1'b0;
        status_nxt    = ST_END;
      end else if (!skip && !opcode_ok(opcode)) begin
        abort_ptr_nxt = PTR_W'(table_r >> 3);
        running_nxt   = 1'b0;
        status_nxt    = ST_ABORT;
      end else begin
        if (!skip && draw_enable_r) begin
          dvalid_nxt = 1'b1;
          kind_nxt   = opcode;
        end
        case (jump)
          JMP_NEXT:   table_nxt = seq_addr;
          JMP_ASSIGN: table_nxt = target_addr;
          JMP_CALL: begin
            // a pending call keeps its return slot
            if (!ret_valid_r) begin
              ret_addr_nxt  = seq_addr;
              ret_valid_nxt = 1'b1;
            end
            table_nxt = target_addr;
          end
          JMP_RETURN: begin
            if (ret_valid_r) begin
              table_nxt     = ret_addr_r;
              ret_valid_nxt = 1'b0;
            end else begin
              table_nxt = seq_addr;
            end
          end
          default: table_nxt = seq_addr;
        endcase
        count_nxt  = count_r + COUNT_W'(1);
        status_nxt = ST_FETCH;
      end
    end

    fetch_nxt = (status_nxt == ST_FETCH) ? FETCH_W'(table_nxt) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plot_mode_r   <= 2'd0;
      draw_enable_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLOT_MODE:   plot_mode_r   <= cfg_data[1:0];
        CFG_DRAW_ENABLE: draw_enable_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_r     <= '0;
      ret_addr_r  <= '0;
      ret_valid_r <= 1'b0;
      count_r     <= '0;
      end_flags_r <= '0;
      running_r   <= 1'b0;
      abort_ptr_r <= '0;
    end else if (accept) begin
      table_r     <= table_nxt;
      ret_addr_r  <= ret_addr_nxt;
      ret_valid_r <= ret_valid_nxt;
      count_r     <= count_nxt;
      end_flags_r <= end_flags_nxt;
      running_r   <= running_nxt;
      abort_ptr_r <= abort_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload; end flags and abort pointer are shown as they stand after the item
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      fetch_r  <= fetch_nxt;
      kind_r   <= kind_nxt;
      dvalid_r <= dvalid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {6'd0, abort_ptr_r, end_flags_r, dvalid_r, kind_r, fetch_r};

`ifndef SYNTHESIS
  a_stop_reason: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(running_r) |-> (status_r == ST_END || status_r == ST_ABORT))
    else $error("walk stopped without end or abort result");

  a_draw_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dvalid_r) |-> (status_r == ST_FETCH))
    else $error("draw dispatch without a next fetch");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_COMMANDS)
    else $error("command count passed its limit");
`endif

endmodule

[tb/sv/draw_command_list_walker_tb.sv]
// Self-checking testbench for draw_command_list_walker: directed and random
// command-table walks, checked against an in-bench walk predictor.
// Depends on dclw_pkg and the draw_command_list_walker RTL.
module draw_command_list_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dclw_pkg::*;

  localparam int MAX_GAP     = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;

  typedef struct packed {
    status_t               status;
    logic [FETCH_W-1:0]    fetch;
    logic [KIND_W-1:0]     kind;
    logic                  valid;
    logic [1:0]            ends;
    logic [PTR_W-1:0]      ptr;
  } walk_result_t;

  class walk_scoreboard;
    logic [1:0]          plot_mode;
    logic                draw_en;
    logic [FETCH_W-1:0]  tbl_addr;
    logic [FETCH_W-1:0]  ret_addr;
    logic                ret_pending;
    logic [COUNT_W-1:0]  cmd_count;
    logic [1:0]          end_flags;
    logic                walking;
    logic [PTR_W-1:0]    abort_ptr;
    walk_result_t        expected_q[$];
    int                  errors;

    function new();
      plot_mode   = 2'd0;
      draw_en     = 1'b1;
      tbl_addr    = '0;
      ret_addr    = '0;
      ret_pending = 1'b0;
      cmd_count   = '0;
      end_flags   = 2'd0;
      walking     = 1'b0;
      abort_ptr   = '0;
      errors      = 0;
    endfunction

    static function bit opcode_legal(logic [3:0] op);
      case (op)
        4'd0, 4'd1, 4'd2, 4'd4, 4'd5, 4'd6, 4'd8, 4'd9, 4'd10: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PLOT_MODE) plot_mode = val;
      else draw_en = val[0];
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Advance the walk by one accepted item and queue the result it causes.
    function void note_input(in_op_t op, logic [CMD_W-1:0] cmd, logic [LINK_W-1:0] link);
      walk_result_t r;
      logic [FETCH_W-1:0] seq;
      logic [FETCH_W-1:0] target;
      logic skip;
      r = '0;
      r.status = ST_IDLE;
      if (op == OP_START) begin
        if (plot_mode != 2'd0) begin
          tbl_addr    = '0;
          ret_addr    = '0;
          ret_pending = 1'b0;
          cmd_count   = '0;
          end_flags   = end_flags >> 1;
          walking     = 1'b1;
          r.status    = ST_FETCH;
        end
      end else if (walking) begin
        skip = cmd[CMD_SKIP_BIT];
        if (cmd[CMD_END_BIT] || cmd_count >= MAX_COMMANDS_DEF) begin
          end_flags = end_flags | 2'b10;
          walking   = 1'b0;
          r.status  = ST_END;
        end else if (!skip && !opcode_legal(cmd[3:0])) begin
          abort_ptr = tbl_addr[FETCH_W-1:3];
          walking   = 1'b0;
          r.status  = ST_ABORT;
        end else begin
          seq    = tbl_addr + FETCH_W'(ENTRY_STEP);
          target = {link, 3'b000};
          if (!skip && draw_en) begin
            r.valid = 1'b1;
            r.kind  = cmd[3:0];
          end
          case (jump_t'(cmd[CMD_JUMP_HI:CMD_JUMP_LO]))
            JMP_NEXT:   tbl_addr = seq;
            JMP_ASSIGN: tbl_addr = target;
            JMP_CALL: begin
              // a pending return slot is kept; a nested call does not overwrite it
              if (!ret_pending) begin
                ret_addr    = seq;
                ret_pending = 1'b1;
              end
              tbl_addr = target;
            end
            default: begin
              if (ret_pending) begin
                tbl_addr    = ret_addr;
                ret_pending = 1'b0;
              end else begin
                tbl_addr = seq;
              end
            end
          endcase
          cmd_count = cmd_count + 1'b1;
          r.status  = ST_FETCH;
          r.fetch   = tbl_addr;
        end
      end
      r.ends = end_flags;
      r.ptr  = abort_ptr;
      expected_q.push_back(r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [47:0] data);
      walk_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h data %0h",
                 $time, st, data);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare("status", e.status, st);
      compare("fetch_address", e.fetch, data[18:0]);
      compare("draw_kind", e.kind, data[22:19]);
      compare("draw_valid", e.valid, data[23]);
      compare("end_status", e.ends, data[25:24]);
      compare("op_pointer", e.ptr, data[41:26]);
      compare("padding", 0, data[47:42]);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [31:0]             in_tdata;
  logic [0:0]              in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [47:0]             out_tdata;
  logic [1:0]              out_tuser;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  bit src_burst;
  bit sink_burst;
  bit hold_req;
  int idle_cycles = 0;

  walk_scoreboard walk_sb = new();

  draw_command_list_walker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Observe every transfer and register write at the edge that takes it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        walk_sb.note_input(in_op_t'(in_tuser), in_tdata[15:0], in_tdata[31:16]);
      if (out_tvalid && out_tready)
        walk_sb.check_result(out_tuser, out_tdata);
      if (cfg_we)
        walk_sb.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stalls, bursts of back-to-back accepts, one long hold.
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = sink_burst ? 0 : $urandom_range(MAX_GAP, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_item(in_op_t op, logic [CMD_W-1:0] cmd, logic [LINK_W-1:0] link);
    int gap;
    gap = src_burst ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {link, cmd};
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop offering and wait until every queued result has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    // let the monitor note the last transfer before looking at the queue
    @(posedge clk);
    while (walk_sb.outstanding() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] pm, logic de);
    drain();
    write_reg(CFG_PLOT_MODE, pm);
    write_reg(CFG_DRAW_ENABLE, {1'b0, de});
  endtask

  function automatic logic [CMD_W-1:0] good_entry();
    logic [CMD_W-1:0] c;
    logic [3:0] op;
    c = CMD_W'($urandom);
    c[CMD_END_BIT]  = 1'b0;
    c[CMD_SKIP_BIT] = ($urandom_range(7, 0) == 0);
    do op = 4'($urandom); while (!walk_scoreboard::opcode_legal(op));
    // skipped entries keep whatever opcode they drew
    if (!c[CMD_SKIP_BIT]) c[3:0] = op;
    return c;
  endfunction

  function automatic logic [CMD_W-1:0] bad_entry();
    logic [CMD_W-1:0] c;
    logic [3:0] op;
    c = CMD_W'($urandom);
    c[CMD_END_BIT]  = 1'b0;
    c[CMD_SKIP_BIT] = 1'b0;
    do op = 4'($urandom); while (walk_scoreboard::opcode_legal(op));
    c[3:0] = op;
    return c;
  endfunction

  function automatic logic [LINK_W-1:0] rand_link();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return 16'hFFFC;
    if (r == 1) return 16'hFFFF;
    return LINK_W'($urandom);
  endfunction

  // Mostly well-formed walks with random content; the rest is noise.
  task automatic random_walks(int count);
    int sent;
    int len;
    int t;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(5, 0) == 0) begin
        src_burst  = ($urandom_range(2, 0) == 0);
        sink_burst = ($urandom_range(2, 0) == 0);
      end
      if ($urandom_range(9, 0) < 8) begin
        send_item(OP_START, CMD_W'($urandom), LINK_W'($urandom));
        len = $urandom_range(15, 1);
        repeat (len) send_item(OP_ENTRY, good_entry(), rand_link());
        sent += len + 1;
        t = $urandom_range(3, 0);
        if (t == 0) send_item(OP_ENTRY, {1'b1, 15'($urandom)}, LINK_W'($urandom));
        else if (t == 1) send_item(OP_ENTRY, bad_entry(), LINK_W'($urandom));
        if (t < 2) sent++;
      end else begin
        send_item(in_op_t'($urandom_range(1, 0)), CMD_W'($urandom), LINK_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    src_burst  = 1'b0;
    sink_burst = 1'b0;
    hold_req   = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plot mode zero after reset: start ignored, entry ignored while idle
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_ENTRY, 16'h0001, 16'h0000);

    set_mode(2'd1, 1'b1);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_ENTRY, 16'h0001, 16'h1234);
    send_item(OP_ENTRY, 16'h1002, 16'hFFFC);   // assign to the top entry
    send_item(OP_ENTRY, 16'h0004, 16'h0000);   // next wraps to zero
    send_item(OP_ENTRY, 16'h2005, 16'h0100);   // call
    send_item(OP_ENTRY, 16'h2006, 16'h0200);   // nested call keeps return slot
    send_item(OP_ENTRY, 16'h3008, 16'h0000);   // return
    send_item(OP_ENTRY, 16'h3009, 16'h0000);   // return with nothing pending
    send_item(OP_ENTRY, 16'h400F, 16'h0000);   // skipped bad opcode
    send_item(OP_ENTRY, 16'h100A, 16'hFFFF);
    send_item(OP_ENTRY, 16'h0003, 16'h0000);   // bad opcode aborts
    send_item(OP_ENTRY, 16'h0000, 16'h0000);   // ignored after abort
    send_item(OP_START, 16'hFFFF, 16'hFFFF);
    send_item(OP_ENTRY, 16'h8000, 16'h0000);   // end bit
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_ENTRY, 16'hC00F, 16'h0000);   // end beats skip and bad opcode
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_ENTRY, 16'h0000, 16'h0000);
    send_item(OP_START, 16'h0000, 16'h0000);   // restart mid-walk
    send_item(OP_ENTRY, 16'hFFFF, 16'hFFFF);

    set_mode(2'd3, 1'b0);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_ENTRY, 16'h0002, 16'h0000);   // walked but not dispatched
    send_item(OP_ENTRY, 16'h4001, 16'h0000);

    // walk long enough to hit the command limit
    set_mode(2'd2, 1'b1);
    send_item(OP_START, 16'h0000, 16'h0000);
    repeat (MAX_COMMANDS_DEF + 1) send_item(OP_ENTRY, good_entry(), rand_link());

    set_mode(2'd1, 1'b1);
    hold_req = 1'b1;
    random_walks(130);
    set_mode(2'd3, 1'b0);
    random_walks(120);
    set_mode(2'd0, 1'b1);
    random_walks(30);
    set_mode(2'd2, 1'b1);
    random_walks(140);
    set_mode(2'd1, 1'b0);
    random_walks(120);
    set_mode(2'd3, 1'b1);
    random_walks(150);

    drain();
    if (walk_sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
design/dclw_pkg.sv
design/draw_command_list_walker.sv
tb/sv/draw_command_list_walker_tb.sv
